// File: rtl/ulms_pkg.sv
// Shared types, widths and codes for the UV / ambient-light measurement sequencer.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package ulms_pkg;

  localparam int RAW_BITS_DEF  = 20;
  localparam int FRAC_BITS_DEF = 8;

  localparam int REQ_W   = 3;
  localparam int UV_W    = 28;
  localparam int LUX_W   = 26;
  localparam int SENS_W  = 16;
  localparam int TGT_W   = 16;
  localparam int SUM_W   = 28;
  localparam int CNT_W   = 8;
  localparam int PHASE_W = 2;
  localparam int MODE_W  = 2;
  // Divisor of the shared divider: largest is sample count times target index.
  localparam int DVS_W   = CNT_W + TGT_W;

  localparam logic [SENS_W-1:0] SENS_RESET = SENS_W'(2300);
  localparam logic [SENS_W-1:0] SENS_MAX   = '1;
  localparam logic [CNT_W-1:0]  CNT_RESET  = CNT_W'(8);
  // lux = raw * 0.6 / 3 = raw / 5
  localparam logic [DVS_W-1:0]  LUX_DIV    = DVS_W'(5);

  // Request codes on the input channel.
  localparam logic [REQ_W-1:0] REQ_RESET    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CALIB    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SET_SENS = 3'd4;

  // Classified operation held in the command queue.
  typedef enum logic [2:0] {
    OP_RESET,
    OP_START,
    OP_SAMPLE,
    OP_CALIB,
    OP_SET_SENS,
    OP_NOP
  } op_e;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_UV   = 2'd1,
    PH_ALS  = 2'd2,
    PH_CAL  = 2'd3
  } phase_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_NONE = 2'd0,
    MODE_UV   = 2'd1,
    MODE_ALS  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DK_UV,
    DK_CAL
  } div_kind_e;

  // Queue entry apart from the raw count, whose width is a parameter.
  typedef struct packed {
    op_e               op;
    logic [TGT_W-1:0]  target;
    logic [SENS_W-1:0] sens;
  } ulms_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ulms_div_stat_t;

endpackage

// File: rtl/ulms_front.sv
// Front end: accepts input transfers, classifies the request code and queues it.
// Two-entry queue toward the back end. Depends on ulms_pkg.
`timescale 1ns / 1ps

module ulms_front import ulms_pkg::*; #(
  parameter int RAW_BITS = RAW_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [RAW_BITS-1:0] raw_count_i,
  input  logic [TGT_W-1:0]    target_index_i,
  input  logic [SENS_W-1:0]   new_sensitivity_i,
  input  logic                pop_i,
  output logic                head_valid_o,
  output ulms_req_t           head_req_o,
  output logic [RAW_BITS-1:0] head_raw_o
);

  localparam int DEPTH = 2;

  ulms_req_t           req_q [DEPTH];
  logic [RAW_BITS-1:0] raw_q [DEPTH];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          cnt_q, cnt_d;
  logic                push;
  ulms_req_t           req_in;

  always_comb begin
    req_in.target = target_index_i;
    req_in.sens   = new_sensitivity_i;
    unique case (req_type_i)
      REQ_RESET:    req_in.op = OP_RESET;
      REQ_START:    req_in.op = OP_START;
      REQ_SAMPLE:   req_in.op = OP_SAMPLE;
      REQ_CALIB:    req_in.op = OP_CALIB;
      REQ_SET_SENS: req_in.op = OP_SET_SENS;
      default:      req_in.op = OP_NOP;
    endcase
  end

  assign in_ready_o   = (cnt_q != 2'(DEPTH));
  assign push         = in_valid_i && in_ready_o;
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_req_o   = req_q[rd_ptr_q];
  assign head_raw_o   = raw_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push  ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q] <= req_in;
      raw_q[wr_ptr_q] <= raw_count_i;
    end
  end

endmodule

// File: rtl/ulms_div.sv
// Restoring divider, one quotient bit per cycle.
// Shared by the UV index and calibration paths. Depends on ulms_pkg.
`timescale 1ns / 1ps

module ulms_div import ulms_pkg::*; #(
  parameter int DVD_W = SUM_W + FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DVD_W-1:0]     dividend_i,
  input  logic [DVS_W-1:0]     divisor_i,
  output ulms_div_stat_t       stat_o,
  output logic [DVD_W-1:0]     quot_o
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVD_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shifted, diff;
  logic             ge;

  // Partial remainder stays below the divisor, so one compare-subtract per bit.
  always_comb begin
    shifted = {rem_q, quo_q[DVD_W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = !diff[DVS_W];
    rem_d   = ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

endmodule

// File: rtl/ulms_back.sv
// Back end: executes queued commands, owns the measurement state and the result.
// Drives the shared divider. Depends on ulms_pkg.
`timescale 1ns / 1ps

module ulms_back import ulms_pkg::*; #(
  parameter int RAW_BITS  = RAW_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int DVD_W     = SUM_W + FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic                head_valid_i,
  input  ulms_req_t           head_req_i,
  input  logic [RAW_BITS-1:0] head_raw_i,
  output logic                pop_o,
  output logic                div_start_o,
  output logic [DVD_W-1:0]    div_dividend_o,
  output logic [DVS_W-1:0]    div_divisor_o,
  input  ulms_div_stat_t      div_stat_i,
  input  logic [DVD_W-1:0]    div_quot_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [UV_W-1:0]     uv_index_o,
  output logic [LUX_W-1:0]    lux_o,
  output logic [PHASE_W-1:0]  phase_o,
  output logic [MODE_W-1:0]   mode_command_o,
  output logic [SENS_W-1:0]   sensitivity_out_o,
  output logic                calib_done_o
);

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'b01,
    ST_DIV    = 2'b10
  } st_e;

  // raw / 5 as a reciprocal multiply: floor(raw * ceil(2^SH / 5) / 2^SH)
  localparam int LUX_SH = RAW_BITS + 3;
  localparam logic [RAW_BITS:0] LUX_RECIP =
    (RAW_BITS + 1)'(((64'd1 << LUX_SH) + 64'd4) / 64'd5);
  localparam int LXW = (RAW_BITS + FRAC_BITS > LUX_W) ? RAW_BITS + FRAC_BITS : LUX_W + 1;

  st_e               st_q, st_d;
  div_kind_e         kind_q, kind_d;
  logic [CNT_W-1:0]  cfg_cnt_q, cfg_cnt_d;
  phase_e            phase_q, phase_d;
  logic [UV_W-1:0]   uv_q, uv_d;
  logic [LUX_W-1:0]  lux_q, lux_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic [TGT_W-1:0]  tgt_q, tgt_d;
  logic [SENS_W-1:0] sens_q, sens_d;
  mode_e             mode_q, mode_d;
  logic              done_q, done_d;
  logic              out_valid_q, out_valid_d;

  logic              out_free;
  logic [CNT_W-1:0]  cnt_eff;
  logic [SENS_W-1:0] sens_nz;
  logic [SENS_W-1:0] set_nz;
  logic [SUM_W:0]    sum_ext;
  logic [SUM_W-1:0]  sum_sat;
  logic [CNT_W-1:0]  left_dec;

  logic [2*RAW_BITS:0]  lux_prod;
  logic [RAW_BITS-3:0]  lux_quo;
  logic [2:0]           lux_rem;
  logic [FRAC_BITS-1:0] lux_frac;
  logic [LXW-1:0]       lux_full;
  logic [LUX_W-1:0]     lux_sat;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (st_q == ST_ACCEPT) && head_valid_i && out_free;
  assign cnt_eff  = (cfg_cnt_q == '0) ? CNT_W'(1) : cfg_cnt_q;
  assign sens_nz  = (sens_q == '0) ? SENS_W'(1) : sens_q;
  assign set_nz   = (head_req_i.sens == '0) ? SENS_W'(1) : head_req_i.sens;
  assign sum_ext  = {1'b0, sum_q} + (SUM_W + 1)'(head_raw_i);
  assign sum_sat  = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign left_dec = left_q - 1'b1;

  // lux = (raw << FRAC_BITS) / 5 = (raw / 5) << FRAC_BITS | (rem << FRAC_BITS) / 5
  assign lux_prod = (2*RAW_BITS + 1)'(head_raw_i) * (2*RAW_BITS + 1)'(LUX_RECIP);
  assign lux_quo  = lux_prod[2*RAW_BITS:LUX_SH];
  // remainder is below 5, so three bits of raw - 5 * quotient are enough
  assign lux_rem  = head_raw_i[2:0] - (lux_quo[2:0] + {lux_quo[0], 2'b00});

  always_comb begin
    unique case (lux_rem)
      3'd0:    lux_frac = '0;
      3'd1:    lux_frac = FRAC_BITS'((1 << FRAC_BITS) / 5);
      3'd2:    lux_frac = FRAC_BITS'((2 << FRAC_BITS) / 5);
      3'd3:    lux_frac = FRAC_BITS'((3 << FRAC_BITS) / 5);
      3'd4:    lux_frac = FRAC_BITS'((4 << FRAC_BITS) / 5);
      default: lux_frac = '0;
    endcase
  end

  assign lux_full = LXW'({lux_quo, lux_frac});
  assign lux_sat  = (|lux_full[LXW-1:LUX_W]) ? '1 : lux_full[LUX_W-1:0];

  always_comb begin
    st_d           = st_q;
    kind_d         = kind_q;
    cfg_cnt_d      = cfg_we_i ? cfg_wdata_i : cfg_cnt_q;
    phase_d        = phase_q;
    uv_d           = uv_q;
    lux_d          = lux_q;
    sum_d          = sum_q;
    left_d         = left_q;
    tgt_d          = tgt_q;
    sens_d         = sens_q;
    mode_d         = mode_q;
    done_d         = done_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    div_start_o    = 1'b0;
    div_dividend_o = DVD_W'(head_raw_i) << FRAC_BITS;
    div_divisor_o  = DVS_W'(sens_nz);

    if (pop_o) begin
      mode_d      = MODE_NONE;
      done_d      = 1'b0;
      out_valid_d = 1'b1;
      unique case (head_req_i.op)
        OP_RESET: begin
          phase_d = PH_IDLE;
          uv_d    = '0;
          lux_d   = '0;
          sum_d   = '0;
          left_d  = '0;
        end
        OP_START: begin
          if (phase_q == PH_IDLE) begin
            phase_d = PH_UV;
            mode_d  = MODE_UV;
          end
        end
        OP_SAMPLE: begin
          unique case (phase_q)
            PH_UV: begin
              div_start_o = 1'b1;
              kind_d      = DK_UV;
              st_d        = ST_DIV;
              out_valid_d = 1'b0;
              phase_d     = PH_ALS;
              mode_d      = MODE_ALS;
            end
            PH_ALS: begin
              lux_d   = lux_sat;
              phase_d = PH_IDLE;
              mode_d  = MODE_UV;
            end
            PH_CAL: begin
              sum_d  = sum_sat;
              left_d = left_dec;
              mode_d = MODE_UV;
              if (left_dec == '0) begin
                phase_d = PH_IDLE;
                done_d  = 1'b1;
                if (tgt_q == '0) begin
                  // no target index: divisor is zero, sensitivity pinned high
                  sens_d = SENS_MAX;
                end else begin
                  div_start_o    = 1'b1;
                  div_dividend_o = DVD_W'(sum_sat) << FRAC_BITS;
                  div_divisor_o  = DVS_W'(cnt_eff) * DVS_W'(tgt_q);
                  kind_d         = DK_CAL;
                  st_d           = ST_DIV;
                  out_valid_d    = 1'b0;
                end
              end
            end
            PH_IDLE: begin
            end
          endcase
        end
        OP_CALIB: begin
          tgt_d   = head_req_i.target;
          sum_d   = '0;
          left_d  = cnt_eff;
          phase_d = PH_CAL;
        end
        OP_SET_SENS: begin
          sens_d = set_nz;
        end
        default: begin
        end
      endcase
    end else if (st_q == ST_DIV && div_stat_i.done) begin
      st_d        = ST_ACCEPT;
      out_valid_d = 1'b1;
      unique case (kind_q)
        DK_UV:
          uv_d = (|div_quot_i[DVD_W-1:UV_W]) ? '1 : div_quot_i[UV_W-1:0];
        DK_CAL: begin
          if (|div_quot_i[DVD_W-1:SENS_W]) begin
            sens_d = SENS_MAX;
          end else if (div_quot_i[SENS_W-1:0] == '0) begin
            sens_d = SENS_W'(1);
          end else begin
            sens_d = div_quot_i[SENS_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_ACCEPT;
      kind_q      <= DK_UV;
      cfg_cnt_q   <= CNT_RESET;
      phase_q     <= PH_IDLE;
      uv_q        <= '0;
      lux_q       <= '0;
      sum_q       <= '0;
      left_q      <= '0;
      tgt_q       <= '0;
      sens_q      <= SENS_RESET;
      mode_q      <= MODE_NONE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      kind_q      <= kind_d;
      cfg_cnt_q   <= cfg_cnt_d;
      phase_q     <= phase_d;
      uv_q        <= uv_d;
      lux_q       <= lux_d;
      sum_q       <= sum_d;
      left_q      <= left_d;
      tgt_q       <= tgt_d;
      sens_q      <= sens_d;
      mode_q      <= mode_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The state registers double as the result register: they only move when
  // the result has been taken.
  assign out_valid_o       = out_valid_q;
  assign uv_index_o        = uv_q;
  assign lux_o             = lux_q;
  assign phase_o           = phase_q;
  assign mode_command_o    = mode_q;
  assign sensitivity_out_o = sens_q;
  assign calib_done_o      = done_q;

endmodule

// File: rtl/uv_light_measurement_sequencer.sv
// Top level of the UV / ambient-light measurement sequencer.
// Instantiates ulms_front, ulms_div and ulms_back; depends on ulms_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o): one event per transfer, request
//   code plus raw count, target index and new sensitivity. Output channel
//   (out_valid_o / out_ready_i): exactly one result transfer per event, in
//   order, carrying UV index, lux, phase, sensor mode to set up next,
//   current sensitivity and a calibration-done flag.
//   cfg_we_i / cfg_wdata_i write the calibration sample count (reset 8); write
//   it only while no event is in flight.
// Throughput
//   Events go through a two-entry queue into the execution stage. Events that
//   need no division, ALS samples included (divide by five as a reciprocal
//   multiply), present their result from the queue entry through the result
//   registers and can follow one per cycle while the output is not stalled.
//   A UV sample and the last calibration sample (nonzero target) use the shared
//   bit-serial divider, one quotient bit per cycle over DVD_W = 28 + FRAC_BITS
//   bits; no later event executes until its quotient is back.
// Reset and stall
//   rst_ni clears the queue and returns to idle with sensitivity 2300.
//   A stalled output holds its result; the queue keeps taking events until
//   both entries are full, then in_ready_o drops.

module uv_light_measurement_sequencer import ulms_pkg::*; #(
  parameter int RAW_BITS  = RAW_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CNT_W-1:0]    cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [RAW_BITS-1:0] raw_count_i,
  input  logic [TGT_W-1:0]    target_index_i,
  input  logic [SENS_W-1:0]   new_sensitivity_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [UV_W-1:0]     uv_index_o,
  output logic [LUX_W-1:0]    lux_o,
  output logic [PHASE_W-1:0]  phase_o,
  output logic [MODE_W-1:0]   mode_command_o,
  output logic [SENS_W-1:0]   sensitivity_out_o,
  output logic                calib_done_o
);

  // Widest dividend: the calibration sum or a raw count, scaled by FRAC_BITS.
  localparam int DVD_W = ((RAW_BITS > SUM_W) ? RAW_BITS : SUM_W) + FRAC_BITS;

  logic                head_valid;
  ulms_req_t           head_req;
  logic [RAW_BITS-1:0] head_raw;
  logic                pop;
  logic                div_start;
  logic [DVD_W-1:0]    div_dividend;
  logic [DVS_W-1:0]    div_divisor;
  ulms_div_stat_t      div_stat;
  logic [DVD_W-1:0]    div_quot;

  ulms_front #(
    .RAW_BITS (RAW_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .req_type_i        (req_type_i),
    .raw_count_i       (raw_count_i),
    .target_index_i    (target_index_i),
    .new_sensitivity_i (new_sensitivity_i),
    .pop_i             (pop),
    .head_valid_o      (head_valid),
    .head_req_o        (head_req),
    .head_raw_o        (head_raw)
  );

  ulms_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  ulms_back #(
    .RAW_BITS  (RAW_BITS),
    .FRAC_BITS (FRAC_BITS),
    .DVD_W     (DVD_W)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .head_valid_i      (head_valid),
    .head_req_i        (head_req),
    .head_raw_i        (head_raw),
    .pop_o             (pop),
    .div_start_o       (div_start),
    .div_dividend_o    (div_dividend),
    .div_divisor_o     (div_divisor),
    .div_stat_i        (div_stat),
    .div_quot_i        (div_quot),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .uv_index_o        (uv_index_o),
    .lux_o             (lux_o),
    .phase_o           (phase_o),
    .mode_command_o    (mode_command_o),
    .sensitivity_out_o (sensitivity_out_o),
    .calib_done_o      (calib_done_o)
  );

endmodule

// File: rtl/ulms_checker.sv
// Port-level checks for the measurement sequencer, bound to its top level.
// Depends on ulms_pkg and uv_light_measurement_sequencer.
`timescale 1ns / 1ps

module ulms_checker import ulms_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [UV_W-1:0]    uv_index_o,
  input logic [PHASE_W-1:0] phase_o,
  input logic [MODE_W-1:0]  mode_command_o,
  input logic [SENS_W-1:0]  sensitivity_out_o,
  input logic               calib_done_o
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(uv_index_o)
      && $stable(sensitivity_out_o) && $stable(phase_o))
    else $error("stalled result changed");

  a_sens_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sensitivity_out_o != '0)
    else $error("sensitivity reported as zero");

  // finishing calibration returns to idle and still asks for UV mode
  a_calib_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calib_done_o |-> phase_o == PH_IDLE && mode_command_o == MODE_UV)
    else $error("calibration end with wrong phase or mode");

  a_als_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && mode_command_o == MODE_ALS |-> phase_o == PH_ALS)
    else $error("ALS mode requested outside ALS phase");

endmodule

bind uv_light_measurement_sequencer ulms_checker u_ulms_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .uv_index_o        (uv_index_o),
  .phase_o           (phase_o),
  .mode_command_o    (mode_command_o),
  .sensitivity_out_o (sensitivity_out_o),
  .calib_done_o      (calib_done_o)
);

// File: dv/uv_light_measurement_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for uv_light_measurement_sequencer: directed events, then
// random event sequences under several calibration sample counts, checked in order.
// Depends on ulms_pkg and the block's RTL only.

import ulms_pkg::*;

// One result transfer as seen on the output channel.
typedef struct packed {
  logic [UV_W-1:0]   uv;
  logic [LUX_W-1:0]  lux;
  phase_e            phase;
  mode_e             mode;
  logic [SENS_W-1:0] sens;
  logic              done;
} reading_t;

// Tracks the sequencer state per accepted event and holds the readings still owed.
class reading_scoreboard;
  localparam longint unsigned UV_TOP   = (64'd1 << UV_W) - 64'd1;
  localparam longint unsigned LUX_TOP  = (64'd1 << LUX_W) - 64'd1;
  localparam longint unsigned SUM_TOP  = (64'd1 << SUM_W) - 64'd1;
  localparam longint unsigned SENS_TOP = (64'd1 << SENS_W) - 64'd1;

  int unsigned       errors;
  logic [CNT_W-1:0]  sample_count;
  phase_e            cur_phase;
  logic [UV_W-1:0]   uv_latest;
  logic [LUX_W-1:0]  lux_latest;
  logic [SUM_W-1:0]  cal_sum;
  logic [CNT_W-1:0]  cal_left;
  logic [TGT_W-1:0]  cal_target;
  logic [SENS_W-1:0] sens_div;
  reading_t          expected_readings[$];

  function new();
    errors       = 0;
    sample_count = CNT_RESET;
    cur_phase    = PH_IDLE;
    uv_latest    = '0;
    lux_latest   = '0;
    cal_sum      = '0;
    cal_left     = '0;
    cal_target   = '0;
    sens_div     = SENS_RESET;
  endfunction

  function void set_sample_count(logic [CNT_W-1:0] value);
    sample_count = value;
  endfunction

  function int pending();
    return expected_readings.size();
  endfunction

  function void note_event(logic [REQ_W-1:0] req, logic [RAW_BITS_DEF-1:0] raw,
                           logic [TGT_W-1:0] tgt, logic [SENS_W-1:0] nsens);
    reading_t          r;
    mode_e             mode;
    logic              done;
    longint unsigned   wide;
    longint unsigned   den;
    logic [CNT_W-1:0]  eff_count;
    mode      = MODE_NONE;
    done      = 1'b0;
    eff_count = (sample_count == '0) ? CNT_W'(1) : sample_count;
    case (req)
      REQ_RESET: begin
        cur_phase  = PH_IDLE;
        uv_latest  = '0;
        lux_latest = '0;
        cal_sum    = '0;
        cal_left   = '0;
      end
      REQ_START: begin
        if (cur_phase == PH_IDLE) begin
          cur_phase = PH_UV;
          mode      = MODE_UV;
        end
      end
      REQ_SAMPLE: begin
        case (cur_phase)
          PH_UV: begin
            wide      = longint'(raw) << FRAC_BITS_DEF;
            wide      = wide / longint'(sens_div);
            uv_latest = (wide > UV_TOP) ? UV_W'(UV_TOP) : UV_W'(wide);
            cur_phase = PH_ALS;
            mode      = MODE_ALS;
          end
          PH_ALS: begin
            wide       = (longint'(raw) << FRAC_BITS_DEF) / longint'(LUX_DIV);
            lux_latest = (wide > LUX_TOP) ? LUX_W'(LUX_TOP) : LUX_W'(wide);
            cur_phase  = PH_IDLE;
            mode       = MODE_UV;
          end
          PH_CAL: begin
            wide     = longint'(cal_sum) + longint'(raw);
            cal_sum  = (wide > SUM_TOP) ? SUM_W'(SUM_TOP) : SUM_W'(wide);
            mode     = MODE_UV;
            cal_left = cal_left - CNT_W'(1);
            if (cal_left == '0) begin
              // divisor uses the sample count in force when the run ends
              den = longint'(eff_count) * longint'(cal_target);
              if (den == 0) begin
                sens_div = SENS_MAX;
              end else begin
                wide = (longint'(cal_sum) << FRAC_BITS_DEF) / den;
                if (wide > SENS_TOP) sens_div = SENS_MAX;
                else if (wide == 0) sens_div = SENS_W'(1);
                else sens_div = SENS_W'(wide);
              end
              cur_phase = PH_IDLE;
              done      = 1'b1;
            end
          end
          default: ;
        endcase
      end
      REQ_CALIB: begin
        cal_target = tgt;
        cal_sum    = '0;
        cal_left   = eff_count;
        cur_phase  = PH_CAL;
      end
      REQ_SET_SENS: begin
        sens_div = (nsens == '0) ? SENS_W'(1) : nsens;
      end
      default: ;
    endcase
    r.uv    = uv_latest;
    r.lux   = lux_latest;
    r.phase = cur_phase;
    r.mode  = mode;
    r.sens  = sens_div;
    r.done  = done;
    expected_readings.push_back(r);
  endfunction

  function void check_reading(reading_t got);
    reading_t want;
    if (expected_readings.size() == 0) begin
      $error("unexpected result transfer: uv_index %0d, phase %0d", got.uv, got.phase);
      errors++;
      return;
    end
    want = expected_readings.pop_front();
    if (got.uv !== want.uv) begin
      $error("uv_index: expected %0d, got %0d", want.uv, got.uv);
      errors++;
    end
    if (got.lux !== want.lux) begin
      $error("lux: expected %0d, got %0d", want.lux, got.lux);
      errors++;
    end
    if (got.phase !== want.phase) begin
      $error("phase: expected %0d, got %0d", want.phase, got.phase);
      errors++;
    end
    if (got.mode !== want.mode) begin
      $error("mode_command: expected %0d, got %0d", want.mode, got.mode);
      errors++;
    end
    if (got.sens !== want.sens) begin
      $error("sensitivity_out: expected %0d, got %0d", want.sens, got.sens);
      errors++;
    end
    if (got.done !== want.done) begin
      $error("calib_done: expected %0d, got %0d", want.done, got.done);
      errors++;
    end
  endfunction
endclass

module uv_light_measurement_sequencer_tb;

  localparam int RAW_W = RAW_BITS_DEF;
  localparam logic [RAW_W-1:0]  RAW_TOP  = '1;
  localparam logic [TGT_W-1:0]  TGT_TOP  = '1;
  localparam logic [SENS_W-1:0] SENS_TOP = '1;
  // request codes the block does not know; it must answer them without any effect
  localparam logic [REQ_W-1:0]  REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_BAD_HI = 3'd7;

  localparam int IDLE_PCT     = 19;
  // transfers numbered in this window see no idling on their side
  localparam int CALM_LO      = 450;
  localparam int CALM_HI      = 560;
  // the receiver holds off this long once the given number of results has come
  localparam int HOLD_AT      = 200;
  localparam int HOLD_CYCLES  = 400;
  // drain time after the last owed result, longer than one divider event
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 300000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CNT_W-1:0]  cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  req_type = '0;
  logic [RAW_W-1:0]  raw_count = '0;
  logic [TGT_W-1:0]  target_index = '0;
  logic [SENS_W-1:0] new_sensitivity = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [UV_W-1:0]   uv_index;
  logic [LUX_W-1:0]  lux;
  logic [PHASE_W-1:0] phase;
  logic [MODE_W-1:0] mode_command;
  logic [SENS_W-1:0] sensitivity_out;
  logic              calib_done;

  int unsigned events_sent = 0;
  int unsigned readings_got = 0;
  int unsigned cycle_count = 0;

  reading_scoreboard sb = new();

  uv_light_measurement_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .raw_count_i       (raw_count),
    .target_index_i    (target_index),
    .new_sensitivity_i (new_sensitivity),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .uv_index_o        (uv_index),
    .lux_o             (lux),
    .phase_o           (phase),
    .mode_command_o    (mode_command),
    .sensitivity_out_o (sensitivity_out),
    .calib_done_o      (calib_done)
  );

  always #5 clk_i = ~clk_i;

  // Offer one event and return at the edge of its transfer. Valid only drops when
  // a gap is taken, so back-to-back events keep valid high without a glitch.
  task automatic send_event(input logic [REQ_W-1:0] req, input logic [RAW_W-1:0] raw,
                            input logic [TGT_W-1:0] tgt, input logic [SENS_W-1:0] nsens);
    if (events_sent < CALM_LO || events_sent >= CALM_HI) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid        <= 1'b1;
    req_type        <= req;
    raw_count       <= raw;
    target_index    <= tgt;
    new_sensitivity <= nsens;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    sb.note_event(req, raw, tgt, nsens);
    events_sent++;
  endtask

  // Sender pause: nothing offered until every owed result has been seen.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Only called with no event in flight.
  task automatic write_sample_count(input logic [CNT_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    sb.set_sample_count(value);
  endtask

  // Result side: check on every transfer, then pick next cycle's ready.
  initial begin : result_sink
    reading_t got;
    int       hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid && out_ready) begin
        got.uv    = uv_index;
        got.lux   = lux;
        got.phase = phase_e'(phase);
        got.mode  = mode_e'(mode_command);
        got.sens  = sensitivity_out;
        got.done  = calib_done;
        sb.check_reading(got);
        readings_got++;
        // long back-pressure: the input queue fills and in_ready drops
        if (readings_got == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (readings_got >= CALM_LO && readings_got < CALM_HI) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [REQ_W-1:0]  req;
    logic [RAW_W-1:0]  raw;
    logic [TGT_W-1:0]  tgt;
    logic [SENS_W-1:0] nsens;
    logic [CNT_W-1:0]  counts [6];
    int                budgets [6];
    int                pick;
    // sample counts per phase: reset value, zero (taken as one), both extremes, a random one, three
    counts  = '{CNT_RESET, 8'd0, 8'd1, 8'd255, 8'd3, 8'd3};
    counts[4] = CNT_W'($urandom_range(4, 254));
    // the 255-sample phase needs room for one whole calibration run
    budgets = '{100, 100, 100, 280, 100, 100};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part, sample count 2 ----
    write_sample_count(8'd2);
    // sample ready while idle is dropped
    send_event(REQ_SAMPLE, RAW_TOP, TGT_TOP, SENS_TOP);
    send_event(REQ_START, '0, '0, '0);
    // start while a reading is running is ignored
    send_event(REQ_START, RAW_TOP, TGT_TOP, SENS_TOP);
    // full-scale UV at the reset sensitivity, then full-scale ALS
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    // direct set of zero turns into one
    send_event(REQ_SET_SENS, RAW_TOP, TGT_TOP, '0);
    send_event(REQ_START, '0, '0, '0);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    send_event(REQ_SAMPLE, '0, '0, '0);
    send_event(REQ_SET_SENS, '0, '0, SENS_TOP);
    // unknown request codes at both ends
    send_event(REQ_BAD_HI, RAW_TOP, TGT_TOP, SENS_TOP);
    send_event(REQ_BAD_LO, '0, '0, '0);
    // zero target index saturates the sensitivity
    send_event(REQ_CALIB, RAW_TOP, '0, SENS_TOP);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    // zero sum gives a zero quotient, which becomes one
    send_event(REQ_CALIB, '0, TGT_TOP, '0);
    send_event(REQ_SAMPLE, '0, '0, '0);
    send_event(REQ_SAMPLE, '0, '0, '0);
    // calibration aborts a running reading; tiny target overflows the quotient
    send_event(REQ_START, '0, '0, '0);
    send_event(REQ_CALIB, '0, TGT_W'(1), '0);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    send_event(REQ_SAMPLE, RAW_TOP, '0, '0);
    // reset event keeps sensitivity; a sample after it is dropped
    send_event(REQ_RESET, RAW_TOP, TGT_TOP, SENS_TOP);
    send_event(REQ_SAMPLE, RAW_W'($urandom()), '0, '0);
    // leave a run half done so the next phase finishes it under a new count
    send_event(REQ_CALIB, '0, TGT_W'(16'h0480), '0);
    send_event(REQ_SAMPLE, RAW_W'($urandom()), '0, '0);

    // ---- random part: mostly well-formed readings and calibrations ----
    for (int ph = 0; ph < 6; ph++) begin
      wait_all_results();
      write_sample_count(counts[ph]);
      for (int n = 0; n < budgets[ph]; n++) begin
        case ($urandom_range(0, 9))
          0:       raw = '0;
          1:       raw = RAW_TOP;
          2, 3:    raw = RAW_W'($urandom_range(0, 4095));
          default: raw = RAW_W'($urandom());
        endcase
        case ($urandom_range(0, 19))
          0:       tgt = '0;
          1:       tgt = TGT_TOP;
          2, 3:    tgt = TGT_W'($urandom_range(1, 255));
          default: tgt = TGT_W'($urandom());
        endcase
        case ($urandom_range(0, 19))
          0:       nsens = '0;
          1:       nsens = SENS_TOP;
          2, 3:    nsens = SENS_W'($urandom_range(1, 15));
          default: nsens = SENS_W'($urandom());
        endcase
        pick = $urandom_range(0, 999);
        case (sb.cur_phase)
          PH_IDLE: begin
            if (pick < 420)      req = REQ_START;
            else if (pick < 570) req = REQ_CALIB;
            else if (pick < 720) req = REQ_SET_SENS;
            else if (pick < 800) req = REQ_RESET;
            else if (pick < 900) req = REQ_SAMPLE;
            else req = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
          end
          PH_CAL: begin
            // aborts kept rare so long runs still complete
            if (pick < 965)      req = REQ_SAMPLE;
            else if (pick < 980) req = REQ_START;
            else if (pick < 990) req = REQ_SET_SENS;
            else if (pick < 998) req = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
            else if (pick < 999) req = REQ_CALIB;
            else req = REQ_RESET;
          end
          default: begin
            if (pick < 900)      req = REQ_SAMPLE;
            else if (pick < 930) req = REQ_START;
            else if (pick < 950) req = REQ_CALIB;
            else if (pick < 970) req = REQ_SET_SENS;
            else if (pick < 985) req = REQ_RESET;
            else req = REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
          end
        endcase
        send_event(req, raw, tgt, nsens);
      end
    end

    wait_all_results();
    // catch any stray transfer after the last owed one
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
